// ===== rtl/core/grs_pkg.sv =====
// ----------------------------------------------------------------------------
// grs_pkg
// Shared widths, constants and controller commands of the Gaussian
// rejection sampler.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int FRAC_BITS = 16;

  localparam int GEN_W    = 31;
  localparam int HR_W     = 23;
  localparam int SAMPLE_W = 24;
  localparam int CNT_W    = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_RANGE = 1'd1;

  localparam logic [GEN_W-1:0] SEED_RESET = 31'd1;
  localparam logic [HR_W-1:0]  HR_RESET   = 23'd4387707;

  localparam logic [GEN_W-1:0] LCG_MOD   = 31'h7FFF_FFFF;
  localparam logic [14:0]      LCG_MUL   = 15'd16807;
  localparam logic [28:0]      LOG2E_Q28 = 29'd387270501;
  localparam logic [29:0]      LN2_Q30   = 30'd744261118;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 31;
  localparam int MUL_P_W = 64;

  // X^2/2 at or above 23 underflows the exponential.
  localparam logic [63:0] UNDERFLOW_LIM = 64'd46 << (2 * FRAC_BITS);
  localparam int T28_SH = 2 * FRAC_BITS + 1 - 28;
  localparam int T28_SH_R = (T28_SH >= 0) ? T28_SH : 0;
  localparam int T28_SH_L = (T28_SH >= 0) ? 0 : -T28_SH;
  localparam int EXP_K_W = 6;
  localparam logic [EXP_K_W-1:0] EXP_K_LIMIT = 6'd33;

  localparam int TAYLOR_TERMS = 13;
  localparam int TERM_CNT_W   = $clog2(TAYLOR_TERMS + 1);
  localparam logic [MUL_A_W-1:0] TERM_ONE = 33'h1_0000_0000;
  localparam int SUM_W = 34;

  // Term divider: a 32-bit dividend, eight quotient bits a cycle.
  localparam int DIV_W      = 32;
  localparam int DIV_DIGIT  = 8;
  localparam int DIV_STEPS  = DIV_W / DIV_DIGIT;
  localparam int DIV_STEP_W = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_LCG,
    OP_FOLD,
    OP_SCALE,
    OP_SQUARE,
    OP_LOG,
    OP_FRAC,
    OP_G30,
    OP_TMUL,
    OP_DIV,
    OP_ACC,
    OP_EVAL,
    OP_COMMIT
  } grs_op_t;

  typedef struct packed {
    grs_op_t                 op;
    logic                    restart;
    logic                    first;
    logic                    sub;
    logic [TERM_CNT_W-1:0]   divisor;
  } grs_cmd_t;

endpackage

// ===== rtl/core/grs_if.sv =====
// ----------------------------------------------------------------------------
// grs_if
// Valid/ready channels of the Gaussian rejection sampler: draw requests in,
// draw results out.
// ----------------------------------------------------------------------------
interface grs_in_if
  import grs_pkg::*;
();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface grs_out_if
  import grs_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic signed [SAMPLE_W-1:0] sample;
  logic [GEN_W-1:0]           generator_value;
  logic [CNT_W-1:0]           trials;
  logic [CNT_W-1:0]           accepts;

  modport source (output valid, output accepted, output sample, output generator_value,
                  output trials, output accepts, input ready);
  modport sink   (input valid, input accepted, input sample, input generator_value,
                  input trials, input accepts, output ready);
endinterface

// ===== rtl/core/grs_ctrl.sv =====
// ----------------------------------------------------------------------------
// grs_ctrl
// Sequencer of the sampler: walks each draw through the shared multiplier
// steps, the Taylor term loop and the term divider, and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module grs_ctrl
  import grs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_restart,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output grs_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LCG,
    S_FOLD,
    S_SCALE,
    S_SQUARE,
    S_LOG,
    S_FRAC,
    S_G30,
    S_TMUL,
    S_DIV,
    S_ACC,
    S_EVAL,
    S_COMMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [TERM_CNT_W-1:0]   n_r, n_nxt;
  logic [DIV_STEP_W-1:0]   step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_free;
  logic                    accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{op: OP_NONE, restart: in_restart, first: 1'b0, sub: 1'b0,
                      divisor: n_r};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_LCG;
        end
      end
      S_LCG: begin
        cmd.op    = OP_LCG;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.op    = OP_FOLD;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.op    = OP_SQUARE;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.op    = OP_LOG;
        state_nxt = S_FRAC;
      end
      S_FRAC: begin
        cmd.op    = OP_FRAC;
        state_nxt = S_G30;
      end
      S_G30: begin
        cmd.op    = OP_G30;
        n_nxt     = TERM_CNT_W'(1);
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        // The previous term is folded into the sum here; odd terms subtract.
        cmd.op    = OP_TMUL;
        cmd.first = (n_r == TERM_CNT_W'(1));
        cmd.sub   = !n_r[0];
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op    = OP_DIV;
        cmd.first = (step_r == '0);
        step_nxt  = step_r + DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(DIV_STEPS - 1)) begin
          if (n_r == TERM_CNT_W'(TAYLOR_TERMS)) begin
            state_nxt = S_ACC;
          end else begin
            n_nxt     = n_r + TERM_CNT_W'(1);
            state_nxt = S_TMUL;
          end
        end
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        cmd.sub   = n_r[0];
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.op    = OP_EVAL;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.op        = OP_COMMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/grs_datapath.sv =====
// ----------------------------------------------------------------------------
// grs_datapath
// Generator, candidate mapping, exponential approximation and counters,
// built round one shared multiplier and an eight-bit-a-cycle term divider.
// ----------------------------------------------------------------------------
module grs_datapath
  import grs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  grs_cmd_t                    cmd,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_idx,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  output logic                        out_accepted,
  output logic signed [SAMPLE_W-1:0]  out_sample,
  output logic [GEN_W-1:0]            out_generator_value,
  output logic [CNT_W-1:0]            out_trials,
  output logic [CNT_W-1:0]            out_accepts
);

  logic [GEN_W-1:0]          seed_r, gen_r, old_r, nxt_r;
  logic [HR_W-1:0]           hr_r;
  logic [CNT_W-1:0]          trials_r, accepts_r;
  logic [MUL_P_W-1:0]        prod_r, prod_nxt;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [SAMPLE_W-1:0]       x_r;
  logic                      zero_r;
  logic [EXP_K_W-1:0]        k_r;
  logic [29:0]               g30_r;
  logic [DIV_W-1:0]          q_r, q_nxt;
  logic [3:0]                rem_r, rem_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_upd;
  logic                      acc_r;

  logic                      out_accepted_r;
  logic [SAMPLE_W-1:0]       out_sample_r;
  logic [GEN_W-1:0]          out_gen_r;
  logic [CNT_W-1:0]          out_trials_r, out_accepts_r;

  // Generator fold: 16807*g = hi*2^31 + lo = hi*M + hi + lo.
  logic [31:0]               lcg_sum;
  logic [GEN_W-1:0]          lcg_nxt;
  // Candidate: floor(2*H*g / M) by the same fold, one correction.
  logic [23:0]               sc_q0;
  logic [31:0]               sc_sum;
  logic [24:0]               sc_q;
  logic [24:0]               x_full;
  logic [SAMPLE_W-1:0]       mag_w;
  logic [HR_W-1:0]           mag;
  logic [63:0]               sq64, t_w;
  logic                      sq_big;
  logic [33:0]               u;
  logic                      k_big;
  logic [32:0]               sum_c, e_val;
  logic [63:0]               lhs, rhs;

  always_comb begin
    lcg_sum = 32'(prod_r[30:0]) + 32'(prod_r[45:31]);
    lcg_nxt = (lcg_sum >= 32'(LCG_MOD)) ? 31'(lcg_sum - 32'(LCG_MOD)) : lcg_sum[30:0];

    sc_q0  = prod_r[54:31];
    sc_sum = 32'(prod_r[30:0]) + 32'(sc_q0);
    sc_q   = 25'(sc_q0) + 25'(sc_sum >= 32'(LCG_MOD));
    x_full = sc_q - 25'(hr_r);

    mag_w = x_r[SAMPLE_W-1] ? (~x_r + SAMPLE_W'(1)) : x_r;
    mag   = mag_w[HR_W-1:0];

    sq64   = 64'(prod_r[45:0]);
    sq_big = (sq64 >= UNDERFLOW_LIM);
    t_w    = (sq64 >> T28_SH_R) << T28_SH_L;

    u     = prod_r[61:28];
    k_big = (u[33:28] >= EXP_K_LIMIT);

    sum_upd = cmd.sub ? (sum_r - SUM_W'(q_r)) : (sum_r + SUM_W'(q_r));

    sum_c = sum_r[SUM_W-1] ? '0 : sum_r[32:0];
    e_val = zero_r ? '0 : (sum_c >> k_r);
    lhs   = {1'b0, nxt_r, 32'd0};
    rhs   = ({31'd0, e_val} << GEN_W) - {31'd0, e_val};
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_LCG: begin
        mul_a = MUL_A_W'(old_r);
        mul_b = MUL_B_W'(LCG_MUL);
      end
      OP_FOLD: begin
        mul_a = MUL_A_W'({hr_r, 1'b0});
        mul_b = old_r;
      end
      OP_SQUARE: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(mag);
      end
      OP_LOG: begin
        mul_a = t_w[MUL_A_W-1:0];
        mul_b = MUL_B_W'(LOG2E_Q28);
      end
      OP_FRAC: begin
        mul_a = MUL_A_W'(u[27:0]);
        mul_b = MUL_B_W'(LN2_Q30);
      end
      OP_TMUL: begin
        mul_a = cmd.first ? TERM_ONE : MUL_A_W'(q_r);
        mul_b = MUL_B_W'(g30_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = {31'd0, mul_a} * {33'd0, mul_b};
  end

  // Term divider: eight restoring steps on a four-bit remainder.
  always_comb begin
    logic [DIV_W-1:0] acc;
    logic [3:0]       rem;
    logic [4:0]       rem5;
    acc = cmd.first ? prod_r[61:30] : q_r;
    rem = cmd.first ? 4'd0 : rem_r;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      rem5 = {rem, acc[DIV_W-1]};
      acc  = {acc[DIV_W-2:0], 1'b0};
      if (rem5 >= {1'b0, cmd.divisor}) begin
        rem5   = rem5 - {1'b0, cmd.divisor};
        acc[0] = 1'b1;
      end
      rem = rem5[3:0];
    end
    q_nxt   = acc;
    rem_nxt = rem;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= SEED_RESET;
      hr_r      <= HR_RESET;
      gen_r     <= SEED_RESET;
      trials_r  <= '0;
      accepts_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SEED:       seed_r <= cfg_data[GEN_W-1:0];
          CFG_HALF_RANGE: hr_r   <= cfg_data[HR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD && cmd.restart) begin
        trials_r  <= '0;
        accepts_r <= '0;
      end
      if (cmd.op == OP_COMMIT) begin
        gen_r <= nxt_r;
        if (trials_r != '1) begin
          trials_r <= trials_r + CNT_W'(1);
        end
        if (acc_r && accepts_r != '1) begin
          accepts_r <= accepts_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (cmd.op)
      OP_LOAD:   old_r <= cmd.restart ? seed_r : gen_r;
      OP_FOLD:   nxt_r <= lcg_nxt;
      OP_SCALE:  x_r   <= x_full[SAMPLE_W-1:0];
      OP_LOG:    zero_r <= sq_big;
      OP_FRAC: begin
        zero_r <= zero_r | k_big;
        k_r    <= u[33:28];
      end
      OP_G30: begin
        g30_r <= prod_r[57:28];
        sum_r <= SUM_W'(TERM_ONE);
      end
      OP_TMUL: begin
        if (!cmd.first) begin
          sum_r <= sum_upd;
        end
      end
      OP_DIV: begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
      end
      OP_ACC:    sum_r <= sum_upd;
      OP_EVAL:   acc_r <= (lhs <= rhs);
      OP_COMMIT: begin
        out_accepted_r <= acc_r;
        out_sample_r   <= acc_r ? x_r : '0;
        out_gen_r      <= nxt_r;
        out_trials_r   <= (trials_r != '1) ? trials_r + CNT_W'(1) : trials_r;
        out_accepts_r  <= (acc_r && accepts_r != '1) ? accepts_r + CNT_W'(1) : accepts_r;
      end
      default: ;
    endcase
  end

  assign out_accepted        = out_accepted_r;
  assign out_sample          = $signed(out_sample_r);
  assign out_generator_value = out_gen_r;
  assign out_trials          = out_trials_r;
  assign out_accepts         = out_accepts_r;

endmodule

// ===== rtl/core/gaussian_rejection_sampler.sv =====
// A new item is taken only once the last one is committed. Each item runs through
// the thirteen Taylor terms, each one pass through the shared multiplier and the
// steps of the eight-bit term divider.
// A waiting result does not block the next item; only the final commit waits.
// Reset (synchronous, rst_n low): generator 1, counters zero, seed 1, half range
// 4387707, no result valid.
// ----------------------------------------------------------------------------
// gaussian_rejection_sampler
// Top level: draw channel in, result channel out, configuration write port.
// ----------------------------------------------------------------------------
module gaussian_rejection_sampler
  import grs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  grs_in_if.sink                 in_ch,
  grs_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  grs_cmd_t cmd;

  grs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .cmd        (cmd)
  );

  grs_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_data            (cfg_data),
    .out_accepted        (out_ch.accepted),
    .out_sample          (out_ch.sample),
    .out_generator_value (out_ch.generator_value),
    .out_trials          (out_ch.trials),
    .out_accepts         (out_ch.accepts)
  );

endmodule

// ===== rtl/core/grs_checker.sv =====
// ----------------------------------------------------------------------------
// grs_checker
// Port-level checks of the sampler's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module grs_checker
  import grs_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_accepted,
  input logic signed [SAMPLE_W-1:0] out_sample,
  input logic [GEN_W-1:0]           out_generator_value,
  input logic [CNT_W-1:0]           out_trials,
  input logic [CNT_W-1:0]           out_accepts
);

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_generator_value)
      && $stable(out_trials) && $stable(out_accepts) && $stable(out_accepted))
    else $error("result payload changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_sample == '0)
    else $error("rejected item carries a nonzero sample");

  a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_accepts <= out_trials && out_trials != '0)
    else $error("accept count exceeds trial count");

  a_accept_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_accepts != '0)
    else $error("accepted item with zero accept count");

endmodule

bind gaussian_rejection_sampler grs_checker u_grs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_accepted        (out_ch.accepted),
  .out_sample          (out_ch.sample),
  .out_generator_value (out_ch.generator_value),
  .out_trials          (out_ch.trials),
  .out_accepts         (out_ch.accepts)
);

// ===== test/grs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_scoreboard
// Watches the draw and result channels and the register port of the sampler.
// It keeps its own copy of the generator, the counters and the registers,
// works out the result of every accepted draw and compares it, field by
// field, with the oldest result still owed.
// ----------------------------------------------------------------------------
module grs_scoreboard
  import grs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  grs_in_if                     in_mon,
  grs_out_if                    out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    owed_count,
  output int                    accepted_total
);

  localparam logic [63:0] MODULUS   = 64'd2147483647;
  localparam logic [63:0] MULT      = 64'd16807;
  localparam logic [63:0] LOG2E_FIX = 64'd387270501;
  localparam logic [63:0] LN2_FIX   = 64'd744261118;
  localparam int          SQ_SHIFT  = 2 * FRAC_BITS + 1 - 28;

  typedef struct {
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] sample;
    logic [GEN_W-1:0]           generator_value;
    logic [CNT_W-1:0]           trials;
    logic [CNT_W-1:0]           accepts;
  } draw_result_t;

  draw_result_t     owed_results[$];
  logic [GEN_W-1:0] seed_reg;
  logic [HR_W-1:0]  half_range_reg;
  logic [GEN_W-1:0] gen_state;
  logic [CNT_W-1:0] trial_cnt;
  logic [CNT_W-1:0] accept_cnt;

  function automatic logic [GEN_W-1:0] step_generator(logic [GEN_W-1:0] g);
    logic [63:0] p;
    logic [63:0] r;
    p = 64'(g) * MULT;
    r = (p & MODULUS) + (p >> 31);
    if (r >= MODULUS) r = r - MODULUS;
    return r[GEN_W-1:0];
  endfunction

  // exp(-X^2/2) in Q32, from the square of X.
  function automatic logic [63:0] bell_height(logic [63:0] sq);
    logic [63:0] t28, u, k, f, g30, term;
    longint sum;
    if (sq >= (64'd46 << (2 * FRAC_BITS))) return 64'd0;
    t28 = (SQ_SHIFT >= 0) ? (sq >> SQ_SHIFT) : (sq << (-SQ_SHIFT));
    u = (t28 * LOG2E_FIX) >> 28;
    k = u >> 28;
    if (k >= 64'd33) return 64'd0;
    f = u & ((64'd1 << 28) - 64'd1);
    g30 = (f * LN2_FIX) >> 28;
    term = 64'd1 << 32;
    sum = longint'(term);
    for (int n = 1; n <= 13; n++) begin
      term = ((term * g30) >> 30) / 64'(n);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum) >> k;
  endfunction

  function automatic draw_result_t predict_draw(logic restart);
    draw_result_t     res;
    logic [GEN_W-1:0] old_g, new_g;
    longint           x;
    logic [63:0]      mag, height;
    logic             acc;
    if (restart) begin
      gen_state  = seed_reg;
      trial_cnt  = '0;
      accept_cnt = '0;
    end
    old_g = gen_state;
    new_g = step_generator(old_g);
    gen_state = new_g;
    x = -longint'(half_range_reg) +
        longint'((64'd2 * 64'(half_range_reg) * 64'(old_g)) / MODULUS);
    mag = (x < 0) ? 64'(-x) : 64'(x);
    height = bell_height(mag * mag);
    acc = ((64'(new_g) << 32) <= height * MODULUS);
    if (trial_cnt != '1) trial_cnt = trial_cnt + CNT_W'(1);
    if (acc && accept_cnt != '1) accept_cnt = accept_cnt + CNT_W'(1);
    res.accepted        = acc;
    res.sample          = acc ? x[SAMPLE_W-1:0] : '0;
    res.generator_value = new_g;
    res.trials          = trial_cnt;
    res.accepts         = accept_cnt;
    return res;
  endfunction

  always @(posedge clk) begin
    draw_result_t want;
    if (!rst_n) begin
      seed_reg       = SEED_RESET;
      half_range_reg = HR_RESET;
      gen_state      = 31'd1;
      trial_cnt      = '0;
      accept_cnt     = '0;
      owed_results.delete();
      fail_count     = 0;
      accepted_total = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_SEED) seed_reg = cfg_data;
        else half_range_reg = cfg_data[HR_W-1:0];
      end
      if (in_mon.valid && in_mon.ready)
        owed_results.push_back(predict_draw(in_mon.restart));
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          $error("result with no draw outstanding");
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_mon.accepted) accepted_total++;
          if (out_mon.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, out_mon.accepted);
            fail_count++;
          end
          if (out_mon.sample !== want.sample) begin
            $error("sample: expected %0d, got %0d", want.sample, out_mon.sample);
            fail_count++;
          end
          if (out_mon.generator_value !== want.generator_value) begin
            $error("generator_value: expected %0d, got %0d", want.generator_value,
                   out_mon.generator_value);
            fail_count++;
          end
          if (out_mon.trials !== want.trials) begin
            $error("trials: expected %0d, got %0d", want.trials, out_mon.trials);
            fail_count++;
          end
          if (out_mon.accepts !== want.accepts) begin
            $error("accepts: expected %0d, got %0d", want.accepts, out_mon.accepts);
            fail_count++;
          end
        end
      end
    end
    owed_count = owed_results.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives draws into the Gaussian rejection sampler under several register
// settings and idling patterns, and gives the verdict from the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import grs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_SEED;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count, owed_count, accepted_total;
  int                    cycles = 0;
  int                    draws_sent = 0;
  int                    sender_idle = 0;
  int                    receiver_stall = 0;

  grs_in_if  in_ch ();
  grs_out_if out_ch ();

  gaussian_rejection_sampler dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  grs_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .fail_count(fail_count), .owed_count(owed_count), .accepted_total(accepted_total)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Here the valid line is only lowered when the sender idles before the next item.
  task automatic send_draw(input logic restart);
    if ($urandom_range(99) < sender_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    draws_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input logic [GEN_W-1:0] seed, input logic [HR_W-1:0] hr);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SEED;
    cfg_data <= seed;
    @(posedge clk);
    cfg_idx  <= CFG_HALF_RANGE;
    cfg_data <= CFG_DATA_W'(hr);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed(input logic [GEN_W-1:0] seed, input logic [HR_W-1:0] hr,
                              input int n);
    drain();
    configure(seed, hr);
    send_draw(1'b1);
    for (int i = 1; i < n; i++) send_draw(1'b0);
  endtask

  initial begin
    logic [HR_W-1:0] hr;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state first, then the register extremes and a stuck generator.
    for (int i = 0; i < 3; i++) send_draw(1'b0);
    run_directed(31'd1, 23'd1, 3);
    run_directed(31'd2147483646, 23'd8388607, 3);
    run_directed(31'd0, HR_RESET, 3);
    run_directed(31'h7FFF_FFFF, HR_RESET, 3);
    run_directed(31'd12345, 23'd65536, 4);
    run_directed(31'd1, HR_RESET, 3);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle = 0;  receiver_stall = 0;  end
        1: begin sender_idle = 80; receiver_stall = 0;  end
        2: begin sender_idle = 0;  receiver_stall = 80; end
        default: begin sender_idle = 30; receiver_stall = 30; end
      endcase
      for (int chunk = 0; chunk < 3; chunk++) begin
        drain();
        // Narrow intervals give many accepted samples; wide ones test underflow.
        if ($urandom_range(1)) hr = HR_W'($urandom_range(8388607, 1));
        else hr = HR_W'($urandom_range(262144, 32768));
        configure(GEN_W'($urandom_range(2147483646, 1)), hr);
        for (int i = 0; i < 150; i++) send_draw($urandom_range(99) < 3);
      end
    end
    sender_idle = 0;
    receiver_stall = 0;
    drain();

    $display("%0d draws under several register settings and idling patterns, %0d accepted.",
             draws_sent, accepted_total);
    if (fail_count == 0 && owed_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
